// ===== rtl/rbsa_pkg.sv =====
package rbsa_pkg;

    // fixed field widths
    localparam int OP_W   = 2;
    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;
    localparam int ROW_W  = 4;
    localparam int OFF_W  = 9;
    localparam int CNT_W  = 10;

    // cell store depth, one entry per index value
    localparam int CELLS = 1 << IDX_W;

    // rows that a ten-bit index can reach
    localparam int MAX_ROWS = IDX_W + 1;

    localparam int ROW_COUNT_DEF = 10;

    // operation codes
    localparam logic [OP_W-1:0] OP_SET    = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // row counter update
    typedef struct packed {
        logic             inc;
        logic             dec;
        logic [ROW_W-1:0] row;
    } t_cnt_cmd;

    // row of an index: position of the top set bit of index + 1
    function automatic logic [ROW_W-1:0] row_of(input logic [IDX_W-1:0] idx);
        logic [IDX_W:0]   n;
        logic [ROW_W-1:0] r;
        n = {1'b0, idx} + {{IDX_W{1'b0}}, 1'b1};
        r = '0;
        for (int i = 0; i <= IDX_W; i++) begin
            if (n[i]) begin
                r = ROW_W'(i);
            end
        end
        return r;
    endfunction

    // first index of a row
    function automatic logic [IDX_W-1:0] row_start(input logic [ROW_W-1:0] r);
        logic [IDX_W:0] s;
        s = ({{IDX_W{1'b0}}, 1'b1} << r) - {{IDX_W{1'b0}}, 1'b1};
        return s[IDX_W-1:0];
    endfunction

endpackage

// ===== rtl/rbsa_if.sv =====
interface rbsa_in_if;
    import rbsa_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output operation, output index, output value, input ready);
    modport sink   (input valid, input operation, input index, input value, output ready);
endinterface

interface rbsa_out_if;
    import rbsa_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic                     row_present;
    logic                     cell_used;
    logic signed [DATA_W-1:0] read_data;
    logic [ROW_W-1:0]         row_number;
    logic [OFF_W-1:0]         row_offset;
    logic [IDX_W-1:0]         highest_index;
    logic                     store_empty;

    modport source (
        output valid, output ok, output row_present, output cell_used, output read_data,
        output row_number, output row_offset, output highest_index, output store_empty,
        input ready
    );
    modport sink (
        input valid, input ok, input row_present, input cell_used, input read_data,
        input row_number, input row_offset, input highest_index, input store_empty,
        output ready
    );
endinterface

// ===== rtl/rbsa_row_counts.sv =====
module rbsa_row_counts #(
    parameter int ROWS = rbsa_pkg::MAX_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rbsa_pkg::t_cnt_cmd i_cmd,
    output logic              o_live_after,
    output logic [ROWS-1:0]   o_row_live
);
    import rbsa_pkg::*;

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [CNT_W-1:0] r_cnt [ROWS];
    logic [RW-1:0]    sel;
    logic             sel_ok;
    logic [CNT_W-1:0] cur;
    logic [CNT_W-1:0] n_cnt;

    assign sel    = i_cmd.row[RW-1:0];
    assign sel_ok = (i_cmd.row < ROW_W'(ROWS));
    assign cur    = sel_ok ? r_cnt[sel] : '0;

    always_comb begin
        n_cnt = cur;
        if (i_cmd.inc) begin
            n_cnt = cur + CNT_W'(1);
        end else if (i_cmd.dec && (cur != '0)) begin
            n_cnt = cur - CNT_W'(1);
        end
    end

    assign o_live_after = (n_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_cnt[r] <= '0;
            end
        end else if ((i_cmd.inc || i_cmd.dec) && sel_ok) begin
            r_cnt[sel] <= n_cnt;
        end
    end

    for (genvar g = 0; g < ROWS; g++) begin : g_live
        assign o_row_live[g] = (r_cnt[g] != '0);
    end

endmodule

// ===== rtl/row_blocked_sparse_array.sv =====
// result: registered by the read-modify-write, then loaded into the output register once free
// items: one at a time, set by the single-entry read-modify-write of the cell memory
// a delete of the highest index adds a downward search: empty rows are skipped, and each
// cell is examined in turn (memory read, then check)
// reset: synchronous, active low; a clearing pass then zeroes every cell of the memory,
// with no input transfer taken until it ends
module row_blocked_sparse_array #(
    parameter int ROW_COUNT = rbsa_pkg::ROW_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rbsa_in_if.sink    i_req,
    rbsa_out_if.source o_rsp
);
    import rbsa_pkg::*;

    // rows that actually exist for a ten-bit index
    localparam int ROWS = (ROW_COUNT < MAX_ROWS) ? ROW_COUNT : MAX_ROWS;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    // last legal index
    localparam logic [31:0] LIMIT = 32'((64'd1 << ROW_COUNT) - 64'd2);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_RMW   = 6'b000100,
        S_WALK  = 6'b001000,
        S_WCHK  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // clearing pass address
    logic [IDX_W-1:0] r_clr, n_clr;

    // captured item
    logic [OP_W-1:0]   r_op;
    logic [IDX_W-1:0]  r_idx;
    logic [DATA_W-1:0] r_val;
    logic              r_idx_ok;
    logic [ROW_W-1:0]  r_row;
    logic [OFF_W-1:0]  r_off;

    // highest in-use index tracking
    logic [IDX_W-1:0] r_top, n_top;
    logic             r_none, n_none;

    // downward search cursor: cell and its row
    logic [IDX_W-1:0] r_wc, n_wc;
    logic [ROW_W-1:0] r_wr, n_wr;

    // result of the current item
    logic              r_ok, n_ok;
    logic              r_present, n_present;
    logic              r_used, n_used;
    logic [DATA_W-1:0] r_data, n_data;

    // output register
    logic              r_o_vld;
    logic              r_o_ok;
    logic              r_o_present;
    logic              r_o_used;
    logic [DATA_W-1:0] r_o_data;
    logic [ROW_W-1:0]  r_o_row;
    logic [OFF_W-1:0]  r_o_off;
    logic [IDX_W-1:0]  r_o_top;
    logic              r_o_none;
    logic              load_out;

    // cell memory: bit DATA_W is the in-use mark, the rest the stored word
    logic [DATA_W:0]   r_mem [CELLS];
    logic [DATA_W:0]   r_rdata;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    logic [DATA_W:0]   mem_wd;
    logic [IDX_W-1:0]  mem_ra;
    logic              rd_used;
    logic [DATA_W-1:0] rd_val;

    // row counters
    t_cnt_cmd          cnt_cmd;
    logic              live_after;
    logic [ROWS-1:0]   row_live;
    logic              wr_live;

    // decode of the incoming index
    logic             acc;
    logic             in_ok;
    logic [ROW_W-1:0] in_row;
    logic [IDX_W-1:0] in_off;
    logic             op_known;

    assign acc    = i_req.valid && i_req.ready;
    assign in_ok  = (32'(i_req.index) <= LIMIT);
    assign in_row = row_of(i_req.index);
    assign in_off = i_req.index - row_start(in_row);

    assign i_req.ready = (r_state == S_IDLE);

    assign op_known = (r_op == OP_SET) || (r_op == OP_READ) || (r_op == OP_DELETE);

    assign rd_used = r_rdata[DATA_W];
    assign rd_val  = r_rdata[DATA_W-1:0];

    assign wr_live = (r_wr < ROW_W'(ROWS)) ? row_live[r_wr[RW-1:0]] : 1'b0;

    // the item's address is read on the transfer edge, the search cursor otherwise
    assign mem_ra = (r_state == S_IDLE) ? i_req.index : r_wc;

    rbsa_row_counts #(
        .ROWS (ROWS)
    ) u_row_counts (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cnt_cmd),
        .o_live_after (live_after),
        .o_row_live   (row_live)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_top     = r_top;
        n_none    = r_none;
        n_wc      = r_wc;
        n_wr      = r_wr;
        n_ok      = r_ok;
        n_present = r_present;
        n_used    = r_used;
        n_data    = r_data;
        cnt_cmd   = '0;
        mem_we    = 1'b0;
        mem_wa    = r_idx;
        mem_wd    = '0;
        load_out  = 1'b0;

        case (r_state)
            S_CLEAR: begin
                // zero mark and word of every cell
                mem_we = 1'b1;
                mem_wa = r_clr;
                n_clr  = r_clr + IDX_W'(1);
                if (r_clr == IDX_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_RMW;
                end
            end

            S_RMW: begin
                // read data of the addressed cell is here; modify and write back
                cnt_cmd.row = r_row;
                cnt_cmd.inc = r_idx_ok && (r_op == OP_SET) && !rd_used;
                cnt_cmd.dec = r_idx_ok && (r_op == OP_DELETE) && rd_used;

                n_present = r_idx_ok && op_known && live_after;
                n_used    = r_idx_ok && op_known && rd_used;
                n_data    = (r_idx_ok && (r_op == OP_READ) && rd_used) ? rd_val : '0;
                n_ok      = r_idx_ok && ((r_op == OP_SET) || (r_op == OP_READ) ||
                                         ((r_op == OP_DELETE) && rd_used));
                n_state   = S_DONE;

                if (r_idx_ok && (r_op == OP_SET)) begin
                    mem_we = 1'b1;
                    mem_wd = {1'b1, r_val};
                    if (r_none || (r_idx > r_top)) begin
                        n_top = r_idx;
                    end
                    n_none = 1'b0;
                end

                if (r_idx_ok && (r_op == OP_DELETE) && rd_used) begin
                    mem_we = 1'b1;
                    mem_wd = '0;
                    if (r_idx == r_top) begin
                        if (r_idx == '0) begin
                            n_top  = '0;
                            n_none = 1'b1;
                        end else begin
                            // search starts just below the deleted maximum
                            n_wc    = r_idx - IDX_W'(1);
                            n_wr    = (r_idx == row_start(r_row)) ? r_row - ROW_W'(1) : r_row;
                            n_state = S_WALK;
                        end
                    end
                end
            end

            S_WALK: begin
                if (!wr_live) begin
                    // empty row: jump to the last cell of the row below
                    if (r_wr == '0) begin
                        n_top   = '0;
                        n_none  = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_wr = r_wr - ROW_W'(1);
                        n_wc = row_start(r_wr) - IDX_W'(1);
                    end
                end else begin
                    // cursor cell is being read
                    n_state = S_WCHK;
                end
            end

            S_WCHK: begin
                if (rd_used) begin
                    n_top   = r_wc;
                    n_state = S_DONE;
                end else if (r_wc == row_start(r_wr)) begin
                    if (r_wr == '0) begin
                        n_top   = '0;
                        n_none  = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_wr    = r_wr - ROW_W'(1);
                        n_wc    = r_wc - IDX_W'(1);
                        n_state = S_WALK;
                    end
                end else begin
                    n_wc    = r_wc - IDX_W'(1);
                    n_state = S_WALK;
                end
            end

            S_DONE: begin
                // wait for the output register to free up
                if (!r_o_vld || o_rsp.ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_top   <= '0;
            r_none  <= 1'b1;
            r_o_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_top   <= n_top;
            r_none  <= n_none;
            if (load_out) begin
                r_o_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op     <= i_req.operation;
            r_idx    <= i_req.index;
            r_val    <= i_req.value;
            r_idx_ok <= in_ok;
            r_row    <= in_ok ? in_row : '0;
            r_off    <= in_ok ? in_off[OFF_W-1:0] : '0;
        end
        r_wc      <= n_wc;
        r_wr      <= n_wr;
        r_ok      <= n_ok;
        r_present <= n_present;
        r_used    <= n_used;
        r_data    <= n_data;
        if (load_out) begin
            r_o_ok      <= r_ok;
            r_o_present <= r_present;
            r_o_used    <= r_used;
            r_o_data    <= r_data;
            r_o_row     <= r_row;
            r_o_off     <= r_off;
            r_o_top     <= r_none ? '0 : r_top;
            r_o_none    <= r_none;
        end
    end

    assign o_rsp.valid         = r_o_vld;
    assign o_rsp.ok            = r_o_ok;
    assign o_rsp.row_present   = r_o_present;
    assign o_rsp.cell_used     = r_o_used;
    assign o_rsp.read_data     = r_o_data;
    assign o_rsp.row_number    = r_o_row;
    assign o_rsp.row_offset    = r_o_off;
    assign o_rsp.highest_index = r_o_top;
    assign o_rsp.store_empty   = r_o_none;

    // no transfer while the memory is still being cleared
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_req.ready)
        else $error("input taken during clearing pass");

    // one item in flight at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("second item taken while one is in flight");

    // an empty store keeps its maximum at zero
    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_none |-> (r_top == '0))
        else $error("maximum index set while store empty");

    // search cursor stays below the deleted maximum in a non-empty store
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WALK) || (r_state == S_WCHK)) |-> (!r_none && (r_wc < r_idx)))
        else $error("search cursor out of range");

    // a failed item never returns data
    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ok) |-> (o_rsp.read_data == '0))
        else $error("data returned on a failed item");

endmodule
